[rtl/core/cheat_code_string_decoder_macros.svh]
// Assertion macros shared by the cheat code decoder RTL.
`ifndef CHEAT_CODE_STRING_DECODER_MACROS_SVH
`define CHEAT_CODE_STRING_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CCSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CCSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ccsd_pkg.sv]
// Types and constants shared by the cheat code decoder modules.
package ccsd_pkg;

   localparam int unsigned NIBBLE_W    = 4;
   localparam int unsigned STORE_W     = 36;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned MARKS_W     = 4;
   localparam logic [COUNT_W-1:0] MAX_DIGITS = 4'd9;

   // ASCII codes of interest
   localparam logic [7:0] ASCII_DASH    = 8'h2D;
   localparam logic [7:0] ASCII_COLON   = 8'h3A;
   localparam logic [7:0] ASCII_0       = 8'h30;
   localparam logic [7:0] ASCII_9       = 8'h39;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_F = 8'h46;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_F = 8'h66;

   // separator mark bit positions
   localparam int unsigned MARK_DASH3  = 0;
   localparam int unsigned MARK_DASH4  = 1;
   localparam int unsigned MARK_DASH6  = 2;
   localparam int unsigned MARK_COLON6 = 3;

   // decode constants
   localparam logic [3:0] GG_ADDR_XOR = 4'hF;
   localparam logic [7:0] GG_CMP_XOR  = 8'hBA;

   typedef enum logic [1:0] {
      CHAR_HEX   = 2'd0,
      CHAR_DASH  = 2'd1,
      CHAR_COLON = 2'd2,
      CHAR_OTHER = 2'd3
   } char_class_type;

   // one classified character, as it travels through the queue
   typedef struct packed {
      char_class_type      char_class;
      logic [NIBBLE_W-1:0] nibble;
      logic                final_char;
   } ccsd_word_type;

endpackage

[rtl/core/ccsd_front.sv]
// Front end: classifies each incoming character into a queue word.
module ccsd_front (
   input  logic [7:0]            character,
   input  logic                  final_char,
   output ccsd_pkg::ccsd_word_type word_out
);

   always_comb begin
      word_out.final_char = final_char;
      word_out.nibble     = '0;
      case (character) inside
         [ccsd_pkg::ASCII_0 : ccsd_pkg::ASCII_9]: begin
            word_out.char_class = ccsd_pkg::CHAR_HEX;
            word_out.nibble     = 4'(character - ccsd_pkg::ASCII_0);
         end
         [ccsd_pkg::ASCII_UPPER_A : ccsd_pkg::ASCII_UPPER_F]: begin
            word_out.char_class = ccsd_pkg::CHAR_HEX;
            word_out.nibble     = 4'(character - ccsd_pkg::ASCII_UPPER_A + 8'd10);
         end
         [ccsd_pkg::ASCII_LOWER_A : ccsd_pkg::ASCII_LOWER_F]: begin
            word_out.char_class = ccsd_pkg::CHAR_HEX;
            word_out.nibble     = 4'(character - ccsd_pkg::ASCII_LOWER_A + 8'd10);
         end
         ccsd_pkg::ASCII_DASH:  word_out.char_class = ccsd_pkg::CHAR_DASH;
         ccsd_pkg::ASCII_COLON: word_out.char_class = ccsd_pkg::CHAR_COLON;
         default:               word_out.char_class = ccsd_pkg::CHAR_OTHER;
      endcase
   end

endmodule

[rtl/core/ccsd_queue.sv]
// Small flop-based FIFO between the classifier and the decode back end.
`include "cheat_code_string_decoder_macros.svh"

module ccsd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  ccsd_pkg::ccsd_word_type push_word,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output ccsd_pkg::ccsd_word_type pop_word
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ccsd_pkg::ccsd_word_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

   `CCSD_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_CNT, "queue overfilled")
   `CCSD_ASSERT_NEXT(a_ptr_track, clock, reset, count_ff == '0 && !push, rd_ptr_ff == wr_ptr_ff, "queue pointers out of step when empty")

endmodule

[rtl/core/ccsd_back.sv]
// Back end: digit store, separator tracking, format check and result register.
`include "cheat_code_string_decoder_macros.svh"

module ccsd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    word_valid,
   output logic                    word_ready,
   input  ccsd_pkg::ccsd_word_type word_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_code_ok,
   output logic                    rsp_code_kind,
   output logic [15:0]             rsp_patch_address,
   output logic [7:0]              rsp_new_value,
   output logic [7:0]              rsp_compare_value,
   output logic                    rsp_has_compare
);

   localparam logic [ccsd_pkg::COUNT_W-1:0] CNT_3 = 4'd3;
   localparam logic [ccsd_pkg::COUNT_W-1:0] CNT_4 = 4'd4;
   localparam logic [ccsd_pkg::COUNT_W-1:0] CNT_6 = 4'd6;
   localparam logic [ccsd_pkg::COUNT_W-1:0] CNT_8 = 4'd8;

   logic [ccsd_pkg::STORE_W-1:0] store_ff, store_in;
   logic [ccsd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [ccsd_pkg::MARKS_W-1:0] marks_ff, marks_in;
   logic                         bad_ff,   bad_in;
   logic                         rsp_valid_ff;
   logic                         ok_ff, kind_ff, has_cmp_ff;
   logic [15:0]                  addr_ff;
   logic [7:0]                   nv_ff, cmp_ff;

   logic [ccsd_pkg::MARKS_W-1:0] mark_sel;
   logic                         pop;
   logic                         ok_in, kind_in, has_cmp_in;
   logic [15:0]                  addr_in;
   logic [7:0]                   nv_in, cmp_in, gi, first_byte;
   logic                         gg_fmt, ar_fmt, kf_fmt;

   // a word is taken whenever the result register is free or being drained
   assign word_ready = !rsp_valid_ff || rsp_ready;
   assign pop        = word_valid && word_ready;

   // state update for one character
   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      marks_in = marks_ff;
      bad_in   = bad_ff;
      mark_sel = '0;
      case (word_in.char_class)
         ccsd_pkg::CHAR_HEX: begin
            if (count_ff >= ccsd_pkg::MAX_DIGITS) begin
               bad_in = 1'b1;
            end else begin
               store_in = {store_ff[ccsd_pkg::STORE_W-ccsd_pkg::NIBBLE_W-1:0], word_in.nibble};
               count_in = count_ff + 1'b1;
            end
         end
         ccsd_pkg::CHAR_DASH: begin
            if (count_ff == CNT_3) begin
               mark_sel[ccsd_pkg::MARK_DASH3] = 1'b1;
            end else if (count_ff == CNT_4) begin
               mark_sel[ccsd_pkg::MARK_DASH4] = 1'b1;
            end else if (count_ff == CNT_6) begin
               mark_sel[ccsd_pkg::MARK_DASH6] = 1'b1;
            end else begin
               bad_in = 1'b1;
            end
         end
         ccsd_pkg::CHAR_COLON: begin
            if (count_ff == CNT_6) begin
               mark_sel[ccsd_pkg::MARK_COLON6] = 1'b1;
            end else begin
               bad_in = 1'b1;
            end
         end
         default: bad_in = 1'b1;
      endcase
      // repeated separator at the same place
      if ((marks_ff & mark_sel) != '0) begin
         bad_in = 1'b1;
      end
      marks_in = marks_ff | mark_sel;
   end

   // format check on the state as it stands after the final character
   always_comb begin
      gi         = {store_in[11:8], store_in[3:0]};
      first_byte = store_in[31:24];
      gg_fmt = !bad_in && (count_in == ccsd_pkg::MAX_DIGITS)
               && !marks_in[ccsd_pkg::MARK_DASH4] && !marks_in[ccsd_pkg::MARK_COLON6];
      kf_fmt = !bad_in && (count_in == CNT_8)
               && ((marks_in & ~(4'b1 << ccsd_pkg::MARK_COLON6)) == '0);
      ar_fmt = !bad_in && (count_in == CNT_8) && (first_byte == 8'h00)
               && (((marks_in & ~(4'b1 << ccsd_pkg::MARK_COLON6)) == '0)
                   || ((marks_in & ~(4'b1 << ccsd_pkg::MARK_DASH4)) == '0));
      ok_in      = 1'b0;
      kind_in    = 1'b0;
      has_cmp_in = 1'b0;
      addr_in    = '0;
      nv_in      = '0;
      cmp_in     = '0;
      if (gg_fmt) begin
         ok_in      = 1'b1;
         has_cmp_in = 1'b1;
         nv_in      = store_in[35:28];
         addr_in    = {store_in[15:12] ^ ccsd_pkg::GG_ADDR_XOR, store_in[27:16]};
         cmp_in     = {gi[1:0], gi[7:2]} ^ ccsd_pkg::GG_CMP_XOR;
      end else if (ar_fmt || kf_fmt) begin
         ok_in   = 1'b1;
         addr_in = store_in[23:8];
         nv_in   = store_in[7:0];
         if (ar_fmt) begin
            kind_in = 1'b1;
         end else begin
            has_cmp_in = 1'b1;
            cmp_in     = first_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff     <= '0;
         count_ff     <= '0;
         marks_ff     <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            if (word_in.final_char) begin
               store_ff     <= '0;
               count_ff     <= '0;
               marks_ff     <= '0;
               bad_ff       <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end else begin
               store_ff <= store_in;
               count_ff <= count_in;
               marks_ff <= marks_in;
               bad_ff   <= bad_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && word_in.final_char) begin
         ok_ff      <= ok_in;
         kind_ff    <= kind_in;
         has_cmp_ff <= has_cmp_in;
         addr_ff    <= addr_in;
         nv_ff      <= nv_in;
         cmp_ff     <= cmp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_ok       = ok_ff;
   assign rsp_code_kind     = kind_ff;
   assign rsp_patch_address = addr_ff;
   assign rsp_new_value     = nv_ff;
   assign rsp_compare_value = cmp_ff;
   assign rsp_has_compare   = has_cmp_ff;

   `CCSD_ASSERT_NEXT(a_final_clears, clock, reset, pop && word_in.final_char, rsp_valid_ff && count_ff == '0 && marks_ff == '0 && !bad_ff, "final word did not load result and clear state")
   `CCSD_ASSERT_SAME(a_bad_zero, clock, reset, rsp_valid_ff && !ok_ff, !kind_ff && !has_cmp_ff && addr_ff == '0 && nv_ff == '0 && cmp_ff == '0, "invalid result carries non-zero fields")
   `CCSD_ASSERT_SAME(a_count_max, clock, reset, 1'b1, count_ff <= ccsd_pkg::MAX_DIGITS, "digit count beyond nine")

endmodule

[rtl/core/cheat_code_string_decoder.sv]
// Top level of the cheat code string decoder.
// Cheat code string decoder. Takes a code string one ASCII character per word
// (hex digits in either case, '-' and ':' as separators) and, on the word
// flagged final_char, returns one result word: a game-genie style patch (nine
// digits, optional dashes after the 3rd and 6th), an action-replay patch ("00"
// plus six digits, optional ':' after six or '-' after four) or a six-plus-two
// patch with compare byte, checked in that order, else code_ok low with every
// other field zero. Non-final words give no result. Throughput is one
// character per clock while the rsp_ side keeps up: the classifier writes a
// small queue and the back end pulls one word a cycle unless a result waits,
// so the rate is set by that single queue read port. rsp_valid rises once
// the final character has passed through the queue entry and been decoded
// straight into the result register, and req_ready only drops when the
// queue fills behind a stalled rsp_ side.
// QUEUE_DEPTH sets the number of queued words and must be a power of two,
// two or more.
module cheat_code_string_decoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // character input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_character,
   input  logic        req_final_char,
   // decoded patch output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_code_ok,
   output logic        rsp_code_kind,
   output logic [15:0] rsp_patch_address,
   output logic [7:0]  rsp_new_value,
   output logic [7:0]  rsp_compare_value,
   output logic        rsp_has_compare
);

   ccsd_pkg::ccsd_word_type front_word;  // classified character
   ccsd_pkg::ccsd_word_type queue_word;  // head of the queue
   logic                    queue_valid;
   logic                    queue_ready;

   // front: hex / dash / colon / other, plus the nibble value
   ccsd_front u_front (
      .character  (req_character),
      .final_char (req_final_char),
      .word_out   (front_word)
   );

   // queue: lets the front keep taking words while a result waits
   ccsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_word  (front_word),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_word   (queue_word)
   );

   // back: digit store, separator marks, format check, result register
   ccsd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .word_valid        (queue_valid),
      .word_ready        (queue_ready),
      .word_in           (queue_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_ok       (rsp_code_ok),
      .rsp_code_kind     (rsp_code_kind),
      .rsp_patch_address (rsp_patch_address),
      .rsp_new_value     (rsp_new_value),
      .rsp_compare_value (rsp_compare_value),
      .rsp_has_compare   (rsp_has_compare)
   );

endmodule

[sim/ccsd_patch_checker.sv]
// Watches both channels of the decoder, predicts each patch word and compares.
`timescale 1ns / 1ps

module ccsd_patch_checker
   import ccsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_character,
   input  logic        req_final_char,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_code_ok,
   input  logic        rsp_code_kind,
   input  logic [15:0] rsp_patch_address,
   input  logic [7:0]  rsp_new_value,
   input  logic [7:0]  rsp_compare_value,
   input  logic        rsp_has_compare,
   output int          mismatch_total,
   output int          patches_pending,
   output int          patches_checked
);

   typedef struct packed {
      logic        code_ok;
      logic        code_kind;
      logic [15:0] patch_address;
      logic [7:0]  new_value;
      logic [7:0]  compare_value;
      logic        has_compare;
   } patch_type;

   localparam logic KIND_GENIE  = 1'b0;
   localparam logic KIND_REPLAY = 1'b1;
   localparam int   REPORT_MAX  = 10;

   localparam logic [MARKS_W-1:0] GENIE_MARKS = 4'((1 << MARK_DASH3) | (1 << MARK_DASH6));
   localparam logic [MARKS_W-1:0] COLON_MARK  = 4'(1 << MARK_COLON6);
   localparam logic [MARKS_W-1:0] DASH4_MARK  = 4'(1 << MARK_DASH4);

   logic [STORE_W-1:0] digit_store;
   logic [COUNT_W-1:0] digit_count;
   logic [MARKS_W-1:0] sep_marks;
   logic               code_broken;
   patch_type          expected_patches[$];

   // digit i of an n-digit string, first arrival is digit 0
   function automatic logic [3:0] digit_of(input logic [STORE_W-1:0] st,
                                          input logic [COUNT_W-1:0] n, input int i);
      logic [STORE_W-1:0] sh;
      sh = st >> (4 * (int'(n) - 1 - i));
      return sh[3:0];
   endfunction

   function automatic patch_type decode_patch(input logic [STORE_W-1:0] st,
                                              input logic [COUNT_W-1:0] n,
                                              input logic [MARKS_W-1:0] m,
                                              input logic broken);
      patch_type  p;
      logic [7:0] gi;
      logic [7:0] lead;
      logic       replay;
      logic       six_two;
      p = '0;
      if (!broken) begin
         if (n == MAX_DIGITS && (m & ~GENIE_MARKS) == '0) begin
            gi = {digit_of(st, n, 6), digit_of(st, n, 8)};
            p.code_ok       = 1'b1;
            p.code_kind     = KIND_GENIE;
            p.has_compare   = 1'b1;
            p.new_value     = {digit_of(st, n, 0), digit_of(st, n, 1)};
            p.patch_address = {digit_of(st, n, 5) ^ GG_ADDR_XOR, digit_of(st, n, 2),
                               digit_of(st, n, 3), digit_of(st, n, 4)};
            p.compare_value = {gi[1:0], gi[7:2]} ^ GG_CMP_XOR;
         end else if (n == 4'd8) begin
            lead    = {digit_of(st, n, 0), digit_of(st, n, 1)};
            six_two = (m & ~COLON_MARK) == '0;
            replay  = lead == 8'h00 && (six_two || (m & ~DASH4_MARK) == '0);
            if (replay || six_two) begin
               p.code_ok       = 1'b1;
               p.patch_address = {digit_of(st, n, 2), digit_of(st, n, 3),
                                  digit_of(st, n, 4), digit_of(st, n, 5)};
               p.new_value     = {digit_of(st, n, 6), digit_of(st, n, 7)};
               if (replay) begin
                  p.code_kind = KIND_REPLAY;
               end else begin
                  p.code_kind     = KIND_GENIE;
                  p.has_compare   = 1'b1;
                  p.compare_value = lead;
               end
            end
         end
      end
      return p;
   endfunction

   always @(posedge clock) begin : track
      patch_type      seen;
      patch_type      want;
      logic [3:0]     nib;
      char_class_type cls;
      int             mk;
      if (reset) begin
         digit_store     = '0;
         digit_count     = '0;
         sep_marks       = '0;
         code_broken     = 1'b0;
         mismatch_total  = 0;
         patches_checked = 0;
         expected_patches.delete();
      end else begin
         // result side first, so a word taken this edge never meets its own patch
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_code_ok, rsp_code_kind, rsp_patch_address, rsp_new_value,
                     rsp_compare_value, rsp_has_compare};
            if (expected_patches.size() == 0) begin
               if (mismatch_total < REPORT_MAX)
                  $display("checker: unexpected result word ok %0b kind %0b addr %h",
                           seen.code_ok, seen.code_kind, seen.patch_address);
               mismatch_total++;
            end else begin
               want = expected_patches.pop_front();
               patches_checked++;
               if (seen !== want) begin
                  if (mismatch_total < REPORT_MAX)
                     $display({"checker: patch mismatch, expected ok %0b kind %0b addr %h ",
                               "new %h cmp %h hc %0b, got ok %0b kind %0b addr %h new %h ",
                               "cmp %h hc %0b"},
                              want.code_ok, want.code_kind, want.patch_address,
                              want.new_value, want.compare_value, want.has_compare,
                              seen.code_ok, seen.code_kind, seen.patch_address,
                              seen.new_value, seen.compare_value, seen.has_compare);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            nib = '0;
            mk  = -1;
            if (req_character >= ASCII_0 && req_character <= ASCII_9) begin
               cls = CHAR_HEX;
               nib = 4'(req_character - ASCII_0);
            end else if (req_character >= ASCII_LOWER_A && req_character <= ASCII_LOWER_F) begin
               cls = CHAR_HEX;
               nib = 4'(req_character - ASCII_LOWER_A + 8'd10);
            end else if (req_character >= ASCII_UPPER_A && req_character <= ASCII_UPPER_F) begin
               cls = CHAR_HEX;
               nib = 4'(req_character - ASCII_UPPER_A + 8'd10);
            end else if (req_character == ASCII_DASH) begin
               cls = CHAR_DASH;
            end else if (req_character == ASCII_COLON) begin
               cls = CHAR_COLON;
            end else begin
               cls = CHAR_OTHER;
            end
            case (cls)
               CHAR_HEX: begin
                  if (digit_count >= MAX_DIGITS) begin
                     code_broken = 1'b1;
                  end else begin
                     digit_store = {digit_store[STORE_W-5:0], nib};
                     digit_count++;
                  end
               end
               CHAR_DASH: begin
                  case (digit_count)
                     4'd3:    mk = MARK_DASH3;
                     4'd4:    mk = MARK_DASH4;
                     4'd6:    mk = MARK_DASH6;
                     default: mk = -1;
                  endcase
               end
               CHAR_COLON: mk = (digit_count == 4'd6) ? MARK_COLON6 : -1;
               default: code_broken = 1'b1;
            endcase
            if (cls == CHAR_DASH || cls == CHAR_COLON) begin
               if (mk < 0) begin
                  code_broken = 1'b1;
               end else begin
                  if (sep_marks[mk]) code_broken = 1'b1;
                  sep_marks[mk] = 1'b1;
               end
            end
            if (req_final_char) begin
               expected_patches.push_back(decode_patch(digit_store, digit_count, sep_marks,
                                                       code_broken));
               digit_store = '0;
               digit_count = '0;
               sep_marks   = '0;
               code_broken = 1'b0;
            end
         end
      end
      patches_pending = expected_patches.size();
   end

endmodule

[sim/tb_cheat_code_string_decoder.sv]
// Stimulus, clock, reset and verdict for the cheat code string decoder.
`timescale 1ns / 1ps

module tb_cheat_code_string_decoder;
   import ccsd_pkg::*;

   localparam int CLOCK_HALF     = 4;     // 8 ns period
   localparam int RANDOM_CHARS   = 1500;  // random part stops once this many words went in
   localparam int HOLD_CYCLES    = 300;   // long result-side stall
   localparam int HOLD_AT_STRING = 40;
   localparam int DRAIN_AT_STRING = 120;
   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
   localparam int TAIL_CYCLES    = 8;

   // shapes of well-formed code strings
   typedef enum int {
      FORM_GENIE,
      FORM_REPLAY,
      FORM_SIX_TWO
   } code_form_type;

   // ways of breaking a well-formed string
   typedef enum int {
      FLAW_REPLACE,
      FLAW_INSERT_SEP,
      FLAW_DROP,
      FLAW_EXTRA_DIGIT,
      FLAW_REPEAT
   } text_flaw_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_character;
   logic        req_final_char;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_code_ok;
   logic        rsp_code_kind;
   logic [15:0] rsp_patch_address;
   logic [7:0]  rsp_new_value;
   logic [7:0]  rsp_compare_value;
   logic        rsp_has_compare;

   int          mismatch_total;
   int          patches_pending;
   int          patches_checked;

   logic [7:0]  code_text[$];     // string being sent, one character per word
   int          chars_sent;
   int          strings_sent;
   int          idle_cycles;
   bit          burst;            // both sides run without gaps while set
   bit          hold_rsp;         // asks the result side for one long stall

   cheat_code_string_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_character     (req_character),
      .req_final_char    (req_final_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_ok       (rsp_code_ok),
      .rsp_code_kind     (rsp_code_kind),
      .rsp_patch_address (rsp_patch_address),
      .rsp_new_value     (rsp_new_value),
      .rsp_compare_value (rsp_compare_value),
      .rsp_has_compare   (rsp_has_compare)
   );

   ccsd_patch_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_character     (req_character),
      .req_final_char    (req_final_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_ok       (rsp_code_ok),
      .rsp_code_kind     (rsp_code_kind),
      .rsp_patch_address (rsp_patch_address),
      .rsp_new_value     (rsp_new_value),
      .rsp_compare_value (rsp_compare_value),
      .rsp_has_compare   (rsp_has_compare),
      .mismatch_total    (mismatch_total),
      .patches_pending   (patches_pending),
      .patches_checked   (patches_checked)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Watchdog: only cycles in which no word moves on either channel count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random hold-off before each word, none in burst stretches,
   // and one long stall on request. Valid is read just after the edge, so it
   // is the value the block saw at that edge.
   initial begin : rsp_side
      int gap;
      bit held;
      rsp_ready = 1'b0;
      held      = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !held) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else begin
            gap = burst ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // hex digit as ASCII, letters in random case
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return ASCII_0 + 8'(v);
      return ($urandom_range(0, 1) ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(v) - 8'd10;
   endfunction

   // One word: optional gap with valid low, then valid held with a steady
   // payload until the edge at which ready is seen high.
   task automatic offer_char(input logic [7:0] ch, input logic fin);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_character  <= ch;
      req_final_char <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   // the whole string, final_char on its last character
   task automatic send_text();
      for (int i = 0; i < code_text.size(); i++)
         offer_char(code_text[i], i == code_text.size() - 1);
      strings_sent++;
   endtask

   task automatic load_text(input string s);
      code_text.delete();
      for (int i = 0; i < s.len(); i++) code_text.push_back(s[i]);
   endtask

   // Sender stops offering and waits until every patch word has been taken.
   // Valid drops and the clock advances first, so the checker has booked the last final character.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (patches_pending == 0);
   endtask

   task automatic build_wellformed(input code_form_type form);
      logic [7:0] lead;
      int         sep;
      code_text.delete();
      case (form)
         FORM_GENIE: begin
            // nine digits, dashes after the 3rd and 6th each optional
            for (int i = 0; i < 9; i++) begin
               code_text.push_back(hex_char(4'($urandom_range(0, 15))));
               if ((i == 2 || i == 5) && $urandom_range(0, 1)) code_text.push_back(ASCII_DASH);
            end
         end
         FORM_REPLAY: begin
            // "00" then six digits; no separator, colon after six or dash after four
            sep = $urandom_range(0, 2);
            code_text.push_back(hex_char(4'h0));
            code_text.push_back(hex_char(4'h0));
            for (int i = 2; i < 8; i++) begin
               code_text.push_back(hex_char(4'($urandom_range(0, 15))));
               if (i == 3 && sep == 2) code_text.push_back(ASCII_DASH);
               if (i == 5 && sep == 1) code_text.push_back(ASCII_COLON);
            end
         end
         default: begin
            // eight digits, optional colon after six; a zero lead byte now and
            // then, which turns it into the action-replay form
            lead = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            code_text.push_back(hex_char(lead[7:4]));
            code_text.push_back(hex_char(lead[3:0]));
            for (int i = 2; i < 8; i++) begin
               code_text.push_back(hex_char(4'($urandom_range(0, 15))));
               if (i == 5 && $urandom_range(0, 1)) code_text.push_back(ASCII_COLON);
            end
         end
      endcase
   endtask

   initial begin : stimulus
      string         directed_codes[$];
      int            pick;
      int            pos;
      int            len;
      int            random_start;
      text_flaw_type flaw;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_character  = 8'h00;
      req_final_char = 1'b0;
      burst          = 1'b0;
      hold_rsp       = 1'b0;
      chars_sent     = 0;
      strings_sent   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: genie with both dashes and mixed case, replay with the
      // dash after four, six-plus-two with colon and top values, a stray
      // letter, a repeated separator, a separator in the wrong place and a
      // tenth digit. Then the lowest and highest byte values alone.
      directed_codes = '{"fA9-0Bc-D71", "0012-3456", "ffFFFF:Ef", "G", "123--", "1-",
                         "0123456789"};
      foreach (directed_codes[i]) begin
         load_text(directed_codes[i]);
         send_text();
      end
      code_text = '{8'h00};
      send_text();
      code_text = '{8'hFF};
      send_text();

      // Random part: mostly well-formed strings with random digits, the rest
      // flawed copies of them and plain noise.
      random_start = chars_sent;
      while (chars_sent - random_start < RANDOM_CHARS) begin
         if (strings_sent == HOLD_AT_STRING) begin
            // result side stalls long while words keep coming: queue fills
            hold_rsp = 1'b1;
            burst    = 1'b1;
         end else if (strings_sent % 6 == 0) begin
            burst = ($urandom_range(0, 3) == 0);
         end
         if (strings_sent == DRAIN_AT_STRING) wait_drained();

         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            build_wellformed(code_form_type'($urandom_range(0, 2)));
         end else if (pick < 9) begin
            build_wellformed(code_form_type'($urandom_range(0, 2)));
            flaw = text_flaw_type'($urandom_range(0, 4));
            pos  = $urandom_range(0, code_text.size() - 1);
            case (flaw)
               FLAW_REPLACE:     code_text[pos] = 8'($urandom_range(0, 255));
               FLAW_INSERT_SEP:  code_text.insert(pos, $urandom_range(0, 1) ? ASCII_DASH
                                                                            : ASCII_COLON);
               FLAW_DROP:        code_text.delete(pos);
               FLAW_EXTRA_DIGIT: code_text.insert(pos, hex_char(4'($urandom_range(0, 15))));
               default:          code_text.insert(pos, code_text[pos]);
            endcase
         end else begin
            // noise: short run of digits, separators and arbitrary bytes
            code_text.delete();
            len = $urandom_range(1, 12);
            repeat (len) begin
               case ($urandom_range(0, 3))
                  0:       code_text.push_back(hex_char(4'($urandom_range(0, 15))));
                  1:       code_text.push_back(ASCII_DASH);
                  2:       code_text.push_back(ASCII_COLON);
                  default: code_text.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end
         send_text();
      end

      burst = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d code strings in %0d character words, %0d patch words checked",
               strings_sent, chars_sent, patches_checked);
      $display("tb: genie, replay and six-plus-two forms, flawed and noise strings, %0d-cycle stall",
               HOLD_CYCLES);
      if (mismatch_total == 0 && patches_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[cheat_code_string_decoder.f]
+incdir+rtl/core
rtl/core/ccsd_pkg.sv
rtl/core/ccsd_front.sv
rtl/core/ccsd_queue.sv
rtl/core/ccsd_back.sv
rtl/core/cheat_code_string_decoder.sv
sim/ccsd_patch_checker.sv
sim/tb_cheat_code_string_decoder.sv
